// File: design/fir_pkg.sv
package fir_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int WEIGHT_W        = 16;
   localparam int PROD_W          = SAMPLE_W + WEIGHT_W;
   localparam int SUM_W           = 35;
   localparam int NUM_WEIGHT_REGS = 8;
   localparam int CSR_INDEX_W     = 8;
   localparam int TAPS_DEFAULT    = 8;

   // register map: tap_weight_k sits at this base plus k
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_WEIGHT_BASE = '0;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic signed [PROD_W-1:0]   product_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

endpackage

// File: design/fir_filter_streaming.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_sample     signed 16, Q1.15
// rsp       out        rsp_valid/rsp_stall  rsp_filtered   signed 35, Q5.30
// csr       in         csr_write_en         csr_index, csr_wdata (tap weights)
//
// one transaction per cycle sustained while rsp_stall stays low; each result passes
// through the product register and then the registered levels of the adder tree
// synchronous active-high reset clears the sample history, weights and all valids
// a stalled result holds its stage; earlier stages keep filling until the pipe
// is full, and only then does req_stall rise
module fir_filter_streaming
   import fir_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sample_type             req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sum_type                rsp_filtered,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  weight_type             csr_wdata
);

   localparam int WREGS = (TAPS < NUM_WEIGHT_REGS) ? TAPS : NUM_WEIGHT_REGS;

   weight_type  weight_ff   [WREGS];
   weight_type  cell_weight [TAPS];
   sample_type  tap_chain   [TAPS+1];
   product_type products    [TAPS];

   logic accept;
   logic tree_ready;
   logic prod_valid_ff;
   logic prod_valid_in;
   logic stage0_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WREGS; k++) begin
            weight_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < WREGS; k++) begin
            if (csr_write_en && csr_index == CSR_TAP_WEIGHT_BASE + CSR_INDEX_W'(k)) begin
               weight_ff[k] <= csr_wdata;
            end
         end
      end
   end

   // taps beyond the register list keep a zero weight
   for (genvar k = 0; k < TAPS; k++) begin : g_weight
      if (k < WREGS) begin : g_reg
         assign cell_weight[k] = weight_ff[k];
      end else begin : g_zero
         assign cell_weight[k] = '0;
      end
   end

   assign stage0_en = !prod_valid_ff || tree_ready;
   assign req_stall = !stage0_en;
   assign accept    = req_valid && stage0_en;

   assign tap_chain[0] = req_sample;

   // the last entry is the oldest sample leaving the chain
   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      fir_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (accept),
         .weight    (cell_weight[k]),
         .tap_data  (tap_chain[k]),
         .pass_data (tap_chain[k+1]),
         .product   (products[k])
      );
   end

   assign prod_valid_in = stage0_en ? req_valid : prod_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   fir_sum_tree #(
      .TAPS (TAPS)
   ) u_sum_tree (
      .clock     (clock),
      .reset     (reset),
      .products  (products),
      .in_valid  (prod_valid_ff),
      .in_ready  (tree_ready),
      .sum_out   (rsp_filtered),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall)
   );

   // accepted sample lands in the product stage
   a_accept_fills_stage0: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> prod_valid_ff)
      else $error("accepted transaction missing from product stage");

   // an empty product stage never holds off the input
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !prod_valid_ff |-> !req_stall)
      else $error("input stalled with empty product stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

// File: design/fir_cell.sv
module fir_cell
   import fir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        shift_en,
   input  weight_type  weight,
   input  sample_type  tap_data,
   output sample_type  pass_data,
   output product_type product
);

   sample_type  sample_ff;
   product_type product_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= tap_data;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         product_ff <= PROD_W'(weight) * PROD_W'(tap_data);
      end
   end

   assign pass_data = sample_ff;
   assign product   = product_ff;

endmodule

// File: design/fir_sum_tree.sv
module fir_sum_tree
   import fir_pkg::*;
#(
   parameter int TAPS = TAPS_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  product_type products [TAPS],
   input  logic        in_valid,
   output logic        in_ready,
   output sum_type     sum_out,
   output logic        out_valid,
   input  logic        out_stall
);

   localparam int LEVELS = $clog2(TAPS);
   localparam int PAD    = 1 << LEVELS;

   sum_type leaf     [PAD];
   sum_type child_lo [1:PAD-1];
   sum_type child_hi [1:PAD-1];
   sum_type tree_ff  [1:PAD-1];
   logic    node_en  [1:PAD-1];

   logic [LEVELS-1:0] valid_ff;
   logic [LEVELS-1:0] valid_in;
   logic [LEVELS-1:0] level_en;

   // zero padding up to a power of two
   for (genvar j = 0; j < PAD; j++) begin : g_leaf
      if (j < TAPS) begin : g_used
         assign leaf[j] = SUM_W'(products[j]);
      end else begin : g_pad
         assign leaf[j] = '0;
      end
   end

   // heap layout: node i adds nodes 2i and 2i+1, root is node 1
   for (genvar i = 1; i < PAD; i++) begin : g_node
      localparam int LVL = LEVELS - $clog2(i + 1);
      if (2 * i >= PAD) begin : g_from_leaf
         assign child_lo[i] = leaf[2 * i - PAD];
         assign child_hi[i] = leaf[2 * i + 1 - PAD];
      end else begin : g_from_node
         assign child_lo[i] = tree_ff[2 * i];
         assign child_hi[i] = tree_ff[2 * i + 1];
      end
      assign node_en[i] = level_en[LVL];
   end

   always_comb begin
      level_en[LEVELS-1] = !valid_ff[LEVELS-1] || !out_stall;
      for (int j = LEVELS - 2; j >= 0; j--) begin
         level_en[j] = !valid_ff[j] || level_en[j+1];
      end
   end

   always_comb begin
      valid_in[0] = level_en[0] ? in_valid : valid_ff[0];
      for (int j = 1; j < LEVELS; j++) begin
         valid_in[j] = level_en[j] ? valid_ff[j-1] : valid_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i < PAD; i++) begin
         if (node_en[i]) begin
            tree_ff[i] <= child_lo[i] + child_hi[i];
         end
      end
   end

   assign in_ready  = level_en[0];
   assign sum_out   = tree_ff[1];
   assign out_valid = valid_ff[LEVELS-1];

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import fir_pkg::*;

   localparam int TAPS         = TAPS_DEFAULT;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int MAX_REPORTS  = 10;
   localparam int TAIL_CYCLES  = 16;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   sample_type req_sample;
   logic rsp_valid;
   logic rsp_stall;
   sum_type rsp_filtered;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   weight_type csr_wdata;

   // predictor state
   weight_type tap_weight [TAPS];
   sample_type sample_hist [TAPS-1];
   sum_type filtered_expected [$];

   int mismatch_count = 0;
   int samples_taken = 0;
   int results_seen = 0;
   int weight_sets = 0;
   int idle_cycles = 0;
   int long_hold_len = 0;
   bit snd_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;

   fir_filter_streaming #(.TAPS(TAPS)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic sum_type filter_sample(input sample_type s);
      logic signed [63:0] acc;
      acc = 64'(tap_weight[0]) * 64'(s);
      for (int k = 1; k < TAPS; k++)
         acc += 64'(tap_weight[k]) * 64'(sample_hist[k-1]);
      for (int k = TAPS - 2; k > 0; k--)
         sample_hist[k] = sample_hist[k-1];
      sample_hist[0] = s;
      return sum_type'(acc[SUM_W-1:0]);
   endfunction

   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic sample_type rand_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return sample_type'(16'sh8000);
      if (r < 6) return sample_type'(16'sh7FFF);
      if (r < 8) return '0;
      if (r < 10) return '1;
      return sample_type'($urandom);
   endfunction

   // predictor: register writes and accepted samples
   always @(posedge clock) begin : predict
      int k;
      if (reset) begin
         foreach (tap_weight[i]) tap_weight[i] = '0;
         foreach (sample_hist[i]) sample_hist[i] = '0;
      end else begin
         if (csr_write_en) begin
            k = int'(csr_index) - int'(CSR_TAP_WEIGHT_BASE);
            if (k >= 0 && k < NUM_WEIGHT_REGS && k < TAPS)
               tap_weight[k] = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            filtered_expected.push_back(filter_sample(req_sample));
            samples_taken++;
         end
      end
   end

   task automatic report_mismatch(input string what, input sum_type want, input sum_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
   endtask

   // result checker
   always @(posedge clock) begin : check
      sum_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (filtered_expected.size() == 0) begin
            report_mismatch("unexpected transaction, filtered", '0, rsp_filtered);
         end else begin
            want = filtered_expected.pop_front();
            if (rsp_filtered !== want)
               report_mismatch("filtered", want, rsp_filtered);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // receiver side stalls
   initial begin : rsp_side
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_len > 0) begin
            n = long_hold_len;
            long_hold_len = 0;
         end else begin
            n = pick_gap(rsp_idle_on);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_sample(input sample_type s);
      int gap;
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = pick_gap(snd_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (filtered_expected.size() != 0) @(posedge clock);
   endtask

   // leaves the write enable high, callers lower it after their last write
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input weight_type data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_weights(input weight_type w [NUM_WEIGHT_REGS]);
      for (int k = 0; k < NUM_WEIGHT_REGS; k++)
         write_reg(CSR_INDEX_W'(CSR_TAP_WEIGHT_BASE + k), w[k]);
      csr_write_en <= 1'b0;
      @(posedge clock);
      weight_sets++;
   endtask

   task automatic test_reset_weights();
      send_sample(sample_type'(16'sh7FFF));
      send_sample(sample_type'(16'sh8000));
      wait_drain();
   endtask

   task automatic test_extreme_sums();
      weight_type w [NUM_WEIGHT_REGS];
      foreach (w[k]) w[k] = weight_type'(16'sh8000);
      load_weights(w);
      repeat (TAPS) send_sample(sample_type'(16'sh8000));
      wait_drain();
      foreach (w[k]) w[k] = weight_type'(16'sh7FFF);
      load_weights(w);
      repeat (TAPS) send_sample(sample_type'(16'sh8000));
      send_sample(sample_type'(16'sh7FFF));
      wait_drain();
   endtask

   task automatic test_unmapped_index();
      weight_type w [NUM_WEIGHT_REGS];
      foreach (w[k]) w[k] = weight_type'(k * 1000 - 3000);
      load_weights(w);
      write_reg(CSR_INDEX_W'(CSR_TAP_WEIGHT_BASE + NUM_WEIGHT_REGS), weight_type'(16'sh7FFF));
      write_reg('1, weight_type'(16'sh8000));
      csr_write_en <= 1'b0;
      send_sample(sample_type'(16'sh1234));
      send_sample(sample_type'(-16'sd77));
      wait_drain();
   endtask

   task automatic test_backpressure();
      snd_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      long_hold_len = 80;
      repeat (40) send_sample(rand_sample());
      wait_drain();
   endtask

   task automatic test_drain_pause();
      snd_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (30) send_sample(rand_sample());
      wait_drain();
      repeat (30) send_sample(rand_sample());
      wait_drain();
   endtask

   task automatic test_random_phases();
      weight_type w [NUM_WEIGHT_REGS];
      int kind;
      int hot;
      while (samples_taken < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 5);
         hot = $urandom_range(0, NUM_WEIGHT_REGS - 1);
         foreach (w[k]) begin
            case (kind)
               0: begin
                  case ($urandom_range(0, 3))
                     0: w[k] = weight_type'(16'sh8000);
                     1: w[k] = weight_type'(16'sh7FFF);
                     2: w[k] = '0;
                     default: w[k] = '1;
                  endcase
               end
               1: begin
                  w[k] = (k == hot) ? weight_type'($urandom) : '0;
               end
               default: begin
                  w[k] = weight_type'($urandom);
               end
            endcase
         end
         load_weights(w);
         snd_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(60, 200)) send_sample(rand_sample());
         wait_drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_weights();
      test_extreme_sums();
      test_unmapped_index();
      test_backpressure();
      test_drain_pause();
      test_random_phases();

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (filtered_expected.size() != 0)
         report_mismatch("missing transaction, filtered", filtered_expected[0], '0);

      $display("filtered %0d samples and checked %0d results over %0d weight sets",
               samples_taken, results_seen, weight_sets);
      $display("with random idling on both sides, a long output stall and %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: fir_filter_streaming.f
design/fir_pkg.sv
design/fir_cell.sv
design/fir_sum_tree.sv
design/fir_filter_streaming.sv
sim/tb.sv
